// ===== design/at_rp_pkg.sv =====
// ----------------------------------------------------------------------------
// at_rp_pkg
// Types and constants shared by the AT response parser modules.
// ----------------------------------------------------------------------------
package at_rp_pkg;

	localparam logic ACT_FEED = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam logic [1:0] STATUS_NOT_READY = 2'd0;
	localparam logic [1:0] STATUS_READY_OK  = 2'd1;
	localparam logic [1:0] STATUS_READY_ERR = 2'd2;

	localparam logic VERDICT_OK    = 1'b0;
	localparam logic VERDICT_ERROR = 1'b1;

	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_O     = 8'h4F;
	localparam logic [7:0] CHR_K     = 8'h4B;
	localparam logic [7:0] CHR_E     = 8'h45;
	localparam logic [7:0] CHR_R     = 8'h52;
	localparam logic [7:0] PRINT_LO  = 8'd32;
	localparam logic [7:0] PRINT_HI  = 8'd126;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
		logic [2:0] read_row;
		logic [6:0] read_col;
	} at_rp_in_t;

	typedef struct packed {
		logic [1:0] parse_status;
		logic       final_status;
		logic [2:0] line_index;
		logic [7:0] read_char;
	} at_rp_out_t;

	typedef struct packed {
		logic [1:0] parse_status;
		logic       final_status;
		logic [2:0] line_index;
	} at_rp_result_t;

endpackage

// ===== design/at_rp_ram.sv =====
// ----------------------------------------------------------------------------
// at_rp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module at_rp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/at_rp_parser.sv =====
// ----------------------------------------------------------------------------
// at_rp_parser
// Response state machine, row and column counters, per-row fill lengths and
// store write requests. Reads past a row's fill length give rd_hit low.
// ----------------------------------------------------------------------------
module at_rp_parser
	import at_rp_pkg::*;
#(
	parameter int MAX_LINES  = 8,
	parameter int LINE_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   feed,
	input  logic [7:0]             rx_byte,
	input  logic [2:0]             read_row,
	input  logic [6:0]             read_col,
	output at_rp_result_t          result,
	output logic                   rd_hit,
	output logic                   wr_en,
	output logic [((MAX_LINES > 1) ? $clog2(MAX_LINES) : 1) + $clog2(LINE_WIDTH)-1:0] wr_addr,
	output logic [7:0]             wr_data
);

	localparam int RW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CW  = $clog2(LINE_WIDTH);
	localparam int CLW = $clog2(LINE_WIDTH + 1);
	localparam int KW  = (CLW > 7) ? CLW : 7;

	typedef enum logic [4:0] {
		S_IDLE, S_CR, S_CRLF, S_O, S_OK, S_OK_CR,
		S_E, S_ER, S_ERR, S_ERRO, S_ERROR, S_ERROR_CR,
		S_LINE, S_LINE_CR, S_LINE_LF, S_BLANK_CR, S_BLANK_LF
	} state_t;

	state_t         state_q, state_n;
	logic [CLW-1:0] column_q, column_n;
	logic           stop_q, stop_n;
	logic [RW-1:0]  row_q, row_n;
	logic           verdict_q, verdict_n;
	logic [CLW-1:0] len_q [MAX_LINES];
	logic [1:0]     status;
	logic           clr;
	logic           put;
	logic           printable;
	logic           row_ok;
	logic [CLW-1:0] rd_len;

	assign printable = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);

	always_comb begin
		state_n   = state_q;
		column_n  = column_q;
		stop_n    = stop_q;
		row_n     = row_q;
		verdict_n = verdict_q;
		status    = STATUS_NOT_READY;
		clr       = 1'b0;
		put       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				clr = 1'b1;
				if (rx_byte == CHR_CR) begin
					state_n = S_CR;
					row_n   = '0;
					stop_n  = 1'b0;
				end else begin
					status = STATUS_READY_ERR;
				end
			end
			S_CR: begin
				if (rx_byte == CHR_LF) state_n = S_CRLF;
				else status = STATUS_READY_ERR;
			end
			S_CRLF: begin
				priority if (rx_byte == CHR_O) begin
					state_n = S_O;
				end else if (rx_byte == CHR_E) begin
					state_n = S_E;
					stop_n  = 1'b0;
				end else if (rx_byte == CHR_PLUS) begin
					state_n = S_LINE;
					stop_n  = 1'b0;
				end else begin
					status = STATUS_READY_ERR;
				end
			end
			S_O: begin
				if (rx_byte == CHR_K) state_n = S_OK;
				else status = STATUS_READY_ERR;
			end
			S_OK: begin
				if (rx_byte == CHR_CR) state_n = S_OK_CR;
				else status = STATUS_READY_ERR;
			end
			S_OK_CR: begin
				if (rx_byte == CHR_LF) begin
					state_n   = S_IDLE;
					stop_n    = 1'b0;
					verdict_n = VERDICT_OK;
					status    = STATUS_READY_OK;
				end else begin
					status = STATUS_READY_ERR;
				end
			end
			S_E: begin
				if (rx_byte == CHR_R) state_n = S_ER;
				else status = STATUS_READY_ERR;
			end
			S_ER: begin
				if (rx_byte == CHR_R) state_n = S_ERR;
				else status = STATUS_READY_ERR;
			end
			S_ERR: begin
				if (rx_byte == CHR_O) state_n = S_ERRO;
				else status = STATUS_READY_ERR;
			end
			S_ERRO: begin
				if (rx_byte == CHR_R) state_n = S_ERROR;
				else status = STATUS_READY_ERR;
			end
			S_ERROR: begin
				if (rx_byte == CHR_CR) state_n = S_ERROR_CR;
				else status = STATUS_READY_ERR;
			end
			S_ERROR_CR: begin
				if (rx_byte == CHR_LF) begin
					state_n   = S_IDLE;
					stop_n    = 1'b0;
					verdict_n = VERDICT_ERROR;
					status    = STATUS_READY_OK;
				end else begin
					status = STATUS_READY_ERR;
				end
			end
			S_LINE: begin
				priority if (printable) begin
					if (column_q < CLW'(LINE_WIDTH)) begin
						put      = !stop_q;
						column_n = column_q + CLW'(1);
					end
				end else if (rx_byte == CHR_CR) begin
					state_n  = S_LINE_CR;
					column_n = '0;
				end else begin
					status = STATUS_READY_ERR;
				end
			end
			S_LINE_CR: begin
				if (rx_byte == CHR_LF) state_n = S_LINE_LF;
				else status = STATUS_READY_ERR;
			end
			S_LINE_LF: begin
				priority if (rx_byte == CHR_PLUS) begin
					state_n = S_LINE;
					if (row_q >= RW'(MAX_LINES - 1)) stop_n = 1'b1;
					else row_n = row_q + RW'(1);
				end else if (rx_byte == CHR_CR) begin
					state_n = S_BLANK_CR;
				end else begin
					status = STATUS_READY_ERR;
				end
			end
			S_BLANK_CR: begin
				if (rx_byte == CHR_LF) state_n = S_BLANK_LF;
				else status = STATUS_READY_ERR;
			end
			S_BLANK_LF: begin
				priority if (rx_byte == CHR_O) state_n = S_O;
				else if (rx_byte == CHR_E) state_n = S_E;
				else status = STATUS_READY_ERR;
			end
			default: begin
				status = STATUS_READY_ERR;
			end
		endcase
		// an error leaves state, column, stop flag and row where they were
		if (status == STATUS_READY_ERR) begin
			state_n  = state_q;
			column_n = column_q;
			stop_n   = stop_q;
			row_n    = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			column_q  <= '0;
			stop_q    <= 1'b0;
			row_q     <= '0;
			verdict_q <= 1'b0;
			for (int i = 0; i < MAX_LINES; i++) len_q[i] <= '0;
		end else if (feed) begin
			state_q   <= state_n;
			column_q  <= column_n;
			stop_q    <= stop_n;
			row_q     <= row_n;
			verdict_q <= verdict_n;
			if (clr) begin
				for (int i = 0; i < MAX_LINES; i++) len_q[i] <= '0;
			end else if (put) begin
				len_q[row_q] <= column_q + CLW'(1);
			end
		end
	end

	always_comb begin
		if (feed) begin
			result.parse_status = status;
			result.final_status = (status == STATUS_READY_OK) ? verdict_n : 1'b0;
			result.line_index   = 3'(row_n);
		end else begin
			result.parse_status = STATUS_NOT_READY;
			result.final_status = 1'b0;
			result.line_index   = 3'(row_q);
		end
	end

	assign wr_en   = feed && put;
	assign wr_addr = {row_q, column_q[CW-1:0]};
	assign wr_data = rx_byte;

	assign row_ok = {4'b0, read_row} < 7'(MAX_LINES);
	assign rd_len = len_q[RW'(read_row)];
	assign rd_hit = row_ok && (KW'(read_col) < KW'(rd_len));

endmodule

// ===== design/at_response_parser_core.sv =====
// ----------------------------------------------------------------------------
// at_response_parser_core
// AT response parser: byte-wise response state machine with a line store
// for '+' lines and single-character reads from that store.
//
//   channel | direction | payload      | handshake
//   req     | in        | at_rp_in_t   | req_valid / req_ready
//   rsp     | out       | at_rp_out_t  | rsp_valid / rsp_ready
//
// One item per cycle while the response is not stalled; each result is registered
// and appears in the cycle after its item is accepted. The store read port is registered too.
// Clearing the store is a reset of per-row fill lengths.
// Reset leaves the parser idle with all rows empty.
// A stalled result holds in the output register; req_ready follows it.
// ----------------------------------------------------------------------------
module at_response_parser_core
	import at_rp_pkg::*;
#(
	parameter int MAX_LINES  = 8,
	parameter int LINE_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  at_rp_in_t  req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output at_rp_out_t rsp
);

	localparam int RW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int CW    = $clog2(LINE_WIDTH);
	localparam int AW    = RW + CW;
	localparam int DEPTH = MAX_LINES * (1 << CW);

	logic          accept;
	logic          feed;
	logic          rd_en;
	at_rp_result_t result;
	logic          rd_hit;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          rsp_valid_q;
	at_rp_result_t result_q;
	logic          hit_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign feed      = accept && (req.action == ACT_FEED);
	assign rd_en     = accept && (req.action == ACT_READ);
	assign rd_addr   = {RW'(req.read_row), CW'(req.read_col)};

	at_rp_parser #(
		.MAX_LINES  (MAX_LINES),
		.LINE_WIDTH (LINE_WIDTH)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.rx_byte  (req.rx_byte),
		.read_row (req.read_row),
		.read_col (req.read_col),
		.result   (result),
		.rd_hit   (rd_hit),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	at_rp_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
			hit_q    <= rd_en && rd_hit;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign rsp.parse_status  = result_q.parse_status;
	assign rsp.final_status  = result_q.final_status;
	assign rsp.line_index    = result_q.line_index;
	assign rsp.read_char     = hit_q ? rd_data : 8'd0;

endmodule
